// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros used by the checker file gis_chk
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// overlapping implication checked on every rising edge outside reset
`define GIS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication whose consequent is checked in the following cycle
`define GIS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/gis_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gis_pkg
// shared types and constants of the gapped interpolation sorter
// ----------------------------------------------------------------------------
package gis_pkg;

  localparam int VAL_W  = 32;
  // home slot never exceeds SPREAD*n, at most 5*64 at the defaults
  localparam int QUOT_W = 10;
  localparam int PROD_W = VAL_W + QUOT_W;
  localparam int STEP_W = 4;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_SLOT_RD,
    ST_SLOT_CHK,
    ST_OUT_RD,
    ST_OUT_CHK,
    ST_FLUSH
  } state_t;

endpackage

// ----- rtl/gis_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gis_ram
// simple dual port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module gis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/gis_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gis_div
// restoring divider, one quotient bit per cycle, quotient known to fit
// ----------------------------------------------------------------------------
module gis_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [gis_pkg::PROD_W-1:0]  dividend,
  input  logic [gis_pkg::VAL_W-1:0]   divisor,
  output logic                        done,
  output logic [gis_pkg::QUOT_W-1:0]  quotient
);

  logic [gis_pkg::PROD_W-1:0] rem;
  logic [gis_pkg::PROD_W-1:0] dvs;
  logic [gis_pkg::STEP_W-1:0] step;
  logic                       active;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem      <= dividend;
        dvs      <= gis_pkg::PROD_W'(divisor) << (gis_pkg::QUOT_W - 1);
        step     <= gis_pkg::STEP_W'(gis_pkg::QUOT_W - 1);
        quotient <= '0;
        active   <= 1'b1;
      end else if (active) begin
        if (rem >= dvs) begin
          rem      <= rem - dvs;
          quotient <= {quotient[gis_pkg::QUOT_W-2:0], 1'b1};
        end else begin
          quotient <= {quotient[gis_pkg::QUOT_W-2:0], 1'b0};
        end
        dvs <= dvs >> 1;
        if (step == '0) begin
          active <= 1'b0;
          done   <= 1'b1;
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/gapped_interpolation_sort.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gapped_interpolation_sort
// loads a set of signed values, places them in a gapped slot store by
// interpolation and streams them out in ascending order
// ----------------------------------------------------------------------------
// usage
//   a request is taken when start is high and busy is low; loading takes one
//   request per cycle. the request with item_last set, or the one that fills
//   MAX_ITEMS, ends the set and raises busy.
//   each value then takes a load memory read, a 32x10 multiply, a 10-step
//   restoring divider and a read-modify-write walk through the slot memory,
//   one slot per cycle, which visits at least one slot.
//   results then appear on strobe with sorted_value, one per occupied slot
//   swept, sorted_last on the final one; the sweep reads one slot per cycle.
//   busy drops the cycle after the last result.
//   results cannot be held off: strobe is valid for a single cycle.
//   after reset the slot memory, SPREAD*MAX_ITEMS+MAX_ITEMS+4 slots (388 at
//   the defaults), is cleared one slot per cycle with busy high.
//   the output sweep clears every slot it emits, so no pass is needed later.
// ----------------------------------------------------------------------------
module gapped_interpolation_sort #(
  parameter int MAX_ITEMS = 64,
  parameter int SPREAD    = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] item_value,
  input  logic        item_last,
  output logic        strobe,
  output logic [31:0] sorted_value,
  output logic        sorted_last
);

  localparam int SLOTS   = SPREAD * MAX_ITEMS + MAX_ITEMS + 4;
  localparam int SLOT_AW = $clog2(SLOTS);
  localparam int LOAD_AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W   = $clog2(MAX_ITEMS + 1);
  localparam int SW      = gis_pkg::VAL_W + 1;

  gis_pkg::state_t state, state_next;

  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          n_items;
  logic [CNT_W-1:0]          idx;
  logic [CNT_W-1:0]          emitted;
  logic [gis_pkg::QUOT_W-1:0] sn;
  logic signed [31:0]        run_min;
  logic signed [31:0]        run_max;
  logic [31:0]               range;
  logic signed [31:0]        x_val;
  logic signed [31:0]        walking;
  logic [gis_pkg::PROD_W-1:0] prod;
  logic [SLOT_AW-1:0]        slot_idx;

  logic                      accept;
  logic                      load_end;
  logic [31:0]               l_rdata;
  logic [31:0]               off;
  logic                      s_we;
  logic [SLOT_AW-1:0]        s_waddr;
  logic [SLOT_AW-1:0]        s_raddr;
  logic [SW-1:0]             s_wdata;
  logic [SW-1:0]             s_rdata;
  logic                      held_valid;
  logic signed [31:0]        held;
  logic                      div_start;
  logic                      div_done;
  logic [gis_pkg::QUOT_W-1:0] quot;
  logic [SLOT_AW-1:0]        home;
  logic                      last_item;

  assign accept     = start && !busy;
  assign load_end   = item_last || (count == CNT_W'(MAX_ITEMS - 1));
  assign off        = l_rdata - run_min;
  assign held_valid = s_rdata[SW-1];
  assign held       = $signed(s_rdata[31:0]);
  assign home       = (range == '0) ? '0 : SLOT_AW'(quot);
  assign last_item  = (idx == n_items - 1'b1);

  gis_ram #(.WIDTH(32), .DEPTH(MAX_ITEMS)) u_load_ram (
    .clk   (clk),
    .we    (accept),
    .waddr (count[LOAD_AW-1:0]),
    .wdata (item_value),
    .raddr (idx[LOAD_AW-1:0]),
    .rdata (l_rdata)
  );

  gis_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_slot_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  gis_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (range),
    .done     (div_done),
    .quotient (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gis_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_we       = 1'b0;
    s_waddr    = slot_idx;
    s_wdata    = '0;
    s_raddr    = slot_idx;
    div_start  = 1'b0;
    busy       = 1'b1;
    case (state)
      gis_pkg::ST_CLEAR: begin
        s_we = 1'b1;
        if (slot_idx == SLOT_AW'(SLOTS - 1)) begin
          state_next = gis_pkg::ST_IDLE;
        end
      end
      gis_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start && load_end) begin
          state_next = gis_pkg::ST_FETCH;
        end
      end
      gis_pkg::ST_FETCH:    state_next = gis_pkg::ST_MUL;
      gis_pkg::ST_MUL:      state_next = gis_pkg::ST_DIV_GO;
      gis_pkg::ST_DIV_GO: begin
        div_start  = 1'b1;
        state_next = gis_pkg::ST_DIV_WAIT;
      end
      gis_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          state_next = gis_pkg::ST_SLOT_RD;
        end
      end
      gis_pkg::ST_SLOT_RD: begin
        s_raddr    = home;
        state_next = gis_pkg::ST_SLOT_CHK;
      end
      gis_pkg::ST_SLOT_CHK: begin
        s_wdata = {1'b1, walking};
        s_we    = !held_valid || (held > walking);
        s_raddr = slot_idx + 1'b1;
        // walk ends on an empty slot, or drops off the end of the store
        if (!held_valid || slot_idx == SLOT_AW'(SLOTS - 1)) begin
          state_next = last_item ? gis_pkg::ST_OUT_RD : gis_pkg::ST_FETCH;
        end
      end
      gis_pkg::ST_OUT_RD:   state_next = gis_pkg::ST_OUT_CHK;
      gis_pkg::ST_OUT_CHK: begin
        s_raddr = slot_idx + 1'b1;
        // emitted slots are cleared on the way past
        s_we    = held_valid;
        s_wdata = {1'b0, s_rdata[31:0]};
        if (held_valid && emitted == n_items - 1'b1) begin
          state_next = gis_pkg::ST_FLUSH;
        end
      end
      gis_pkg::ST_FLUSH:    state_next = gis_pkg::ST_IDLE;
      default:              state_next = gis_pkg::ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      run_min  <= '0;
      run_max  <= '0;
      slot_idx <= '0;
      strobe   <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        gis_pkg::ST_CLEAR: begin
          slot_idx <= slot_idx + 1'b1;
        end
        gis_pkg::ST_IDLE: begin
          if (accept) begin
            if (count == '0) begin
              run_min <= $signed(item_value);
              run_max <= $signed(item_value);
            end else begin
              if ($signed(item_value) < run_min) run_min <= $signed(item_value);
              if ($signed(item_value) > run_max) run_max <= $signed(item_value);
            end
            if (load_end) begin
              count   <= '0;
              n_items <= count + 1'b1;
              sn      <= gis_pkg::QUOT_W'(SPREAD * (int'(count) + 1));
              idx     <= '0;
            end else begin
              count <= count + 1'b1;
            end
          end
        end
        gis_pkg::ST_FETCH: begin
          range <= run_max - run_min;
        end
        gis_pkg::ST_MUL: begin
          x_val <= $signed(l_rdata);
          prod  <= gis_pkg::PROD_W'(off) * gis_pkg::PROD_W'(sn);
        end
        gis_pkg::ST_SLOT_RD: begin
          slot_idx <= home;
          walking  <= x_val;
        end
        gis_pkg::ST_SLOT_CHK: begin
          slot_idx <= slot_idx + 1'b1;
          if (held_valid && held > walking) begin
            walking <= held;
          end
          if (!held_valid || slot_idx == SLOT_AW'(SLOTS - 1)) begin
            idx      <= idx + 1'b1;
            slot_idx <= '0;
            emitted  <= '0;
          end
        end
        gis_pkg::ST_OUT_CHK: begin
          slot_idx <= slot_idx + 1'b1;
          if (held_valid) begin
            strobe       <= 1'b1;
            sorted_value <= s_rdata[31:0];
            sorted_last  <= (emitted == n_items - 1'b1);
            emitted      <= emitted + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- rtl/gis_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gis_chk
// port level checks of the gapped interpolation sorter
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gis_chk (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [31:0] item_value,
  input logic        item_last,
  input logic        strobe,
  input logic [31:0] sorted_value,
  input logic        sorted_last
);

  `GIS_ASSERT_IMP(a_strobe_busy, strobe, busy, "result while not busy")
  `GIS_ASSERT_IMP(a_last_strobe, sorted_last && strobe, busy, "last result while idle")
  `GIS_ASSERT_NXT(a_last_idle, strobe && sorted_last, !busy && !strobe, "no release after last")
  `GIS_ASSERT_NXT(a_end_busy, start && !busy && item_last, busy, "final request left idle")
  `GIS_ASSERT_NXT(a_ascend, strobe && !sorted_last, !strobe || ($signed(sorted_value) >= $signed($past(sorted_value))), "results out of order")

endmodule

bind gapped_interpolation_sort gis_chk u_gis_chk (.*);
